>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the voxel density RTL. They fall away in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property checked on every rising edge outside reset
`define TSVD_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("tsvd assertion failed");

// expression that must never be true outside reset
`define TSVD_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("tsvd forbidden condition");

`else

`define TSVD_ASSERT(lbl, clk, rst_n, prop)
`define TSVD_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

>>> src/tsvd_pkg.sv
// ----------------------------------------------------------------------------
// tsvd_pkg
// Widths, codes and payload types of the tapered segment voxel density core.
// ----------------------------------------------------------------------------
package tsvd_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int SCALE_FRAC = 16;
	localparam int VOX_W      = 20;
	localparam int POS_W      = 32;
	localparam int FLOW_W     = 32;
	localparam int K_W        = 5;
	localparam int COORD_W    = 31;
	localparam int Q_W        = 31;
	localparam logic [Q_W-1:0] INV_PI_Q32 = 31'd1367130551;
	localparam int FLOW_RW    = ((Q_W + FRAC_BITS + 1) / 2) * 2;
	localparam int SROOT_W    = FLOW_RW / 2;
	localparam int RAD_W      = SROOT_W + K_W;
	localparam int T_W        = FRAC_BITS + 1;
	localparam int LEN2_W     = 2 * COORD_W;
	localparam int DIST2_W    = 2 * (COORD_W + 1);
	localparam int DIST_W     = DIST2_W / 2;
	localparam int DQ_W       = 8;
	localparam int DX_W       = K_W + DQ_W;
	localparam int FZ_W       = K_W + FRAC_BITS;

	localparam logic signed [COORD_W+7:0] DIFF_LIM = 39'sd1073741823;

	typedef enum logic [1:0] {
		REG_INFLATION,
		REG_SCALE,
		REG_MIN_RADIUS,
		REG_JUMP_LIMIT
	} reg_idx_t;

	typedef enum logic [1:0] {
		T_ZERO,
		T_ONE,
		T_DIV
	} tmode_t;

	typedef enum logic [1:0] {
		D_FULL,
		D_EMPTY,
		D_DIV
	} dclass_t;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [RAD_W-1:0] radius_t;

	typedef struct packed {
		coord_t [2:0] pa;
		coord_t [2:0] ab;
		logic [7:0]   prior;
	} geo_t;

	typedef struct packed {
		coord_t [2:0] pa;
		coord_t [2:0] ab;
		radius_t      ra;
		radius_t      rb;
		tmode_t       mode;
		logic [7:0]   prior;
	} seg_t;

	typedef struct packed {
		radius_t    rad;
		logic [7:0] prior;
	} dist_pay_t;

	typedef struct packed {
		dclass_t    cls;
		logic [7:0] prior;
	} dens_pay_t;

	function automatic coord_t sat_coord(input logic signed [COORD_W+7:0] x);
		if (x > DIFF_LIM) begin
			return DIFF_LIM[COORD_W-1:0];
		end else if (x < -DIFF_LIM) begin
			return coord_t'(-DIFF_LIM);
		end
		return x[COORD_W-1:0];
	endfunction

endpackage

>>> src/tsvd_isqrt.sv
// ----------------------------------------------------------------------------
// tsvd_isqrt
// Pipelined integer square root, one result bit per stage, with sideband.
// ----------------------------------------------------------------------------
module tsvd_isqrt #(
	parameter int RW    = 64,
	parameter int LANES = 1,
	parameter int PW    = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [LANES-1:0][RW-1:0]      rad,
	input  logic [PW-1:0]                 in_pay,
	output logic                          out_valid,
	output logic [LANES-1:0][RW/2-1:0]    root,
	output logic [PW-1:0]                 out_pay
);

	localparam int N = RW / 2;

	logic                     vld_s [N];
	logic [LANES-1:0][RW-1:0] rem_s [N];
	logic [LANES-1:0][RW-1:0] res_s [N];
	logic [PW-1:0]            pay_s [N];

	for (genvar g = 0; g < N; g++) begin : g_step
		localparam logic [RW-1:0] BIT = RW'(1) << (2 * (N - 1 - g));

		logic [LANES-1:0][RW-1:0] rem_in, res_in, rem_nx, res_nx;
		logic [LANES-1:0][RW:0]   trial;
		logic                     vld_in;
		logic [PW-1:0]            pay_in;

		if (g == 0) begin : g_first
			assign rem_in = rad;
			assign res_in = '0;
			assign vld_in = in_valid;
			assign pay_in = in_pay;
		end else begin : g_next
			assign rem_in = rem_s[g-1];
			assign res_in = res_s[g-1];
			assign vld_in = vld_s[g-1];
			assign pay_in = pay_s[g-1];
		end

		always_comb begin
			for (int i = 0; i < LANES; i++) begin
				trial[i] = {1'b0, res_in[i]} + {1'b0, BIT};
				if ({1'b0, rem_in[i]} >= trial[i]) begin
					rem_nx[i] = rem_in[i] - trial[i][RW-1:0];
					res_nx[i] = (res_in[i] >> 1) + BIT;
				end else begin
					rem_nx[i] = rem_in[i];
					res_nx[i] = res_in[i] >> 1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (en) begin
				vld_s[g] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g] <= rem_nx;
				res_s[g] <= res_nx;
				pay_s[g] <= pay_in;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			root[i] = res_s[N-1][i][N-1:0];
		end
	end

	assign out_valid = vld_s[N-1];
	assign out_pay   = pay_s[N-1];

endmodule

>>> src/tsvd_div.sv
// ----------------------------------------------------------------------------
// tsvd_div
// Pipelined restoring divider for a fraction x/d with x < d, one quotient
// bit per stage, giving floor(x * 2^QW / d).
// ----------------------------------------------------------------------------
module tsvd_div #(
	parameter int DW = 62,
	parameter int QW = 16,
	parameter int PW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [DW-1:0] x,
	input  logic [DW-1:0] d,
	input  logic [PW-1:0] in_pay,
	output logic          out_valid,
	output logic [QW-1:0] quo,
	output logic [PW-1:0] out_pay
);

	logic          vld_s [QW];
	logic [DW-1:0] rem_s [QW];
	logic [DW-1:0] d_s   [QW];
	logic [QW-1:0] q_s   [QW];
	logic [PW-1:0] pay_s [QW];

	for (genvar g = 0; g < QW; g++) begin : g_step
		logic [DW-1:0] rem_in, d_in, rem_nx;
		logic [QW-1:0] q_in, q_nx;
		logic [DW:0]   r2;
		logic          vld_in;
		logic [PW-1:0] pay_in;

		if (g == 0) begin : g_first
			assign rem_in = x;
			assign d_in   = d;
			assign q_in   = '0;
			assign vld_in = in_valid;
			assign pay_in = in_pay;
		end else begin : g_next
			assign rem_in = rem_s[g-1];
			assign d_in   = d_s[g-1];
			assign q_in   = q_s[g-1];
			assign vld_in = vld_s[g-1];
			assign pay_in = pay_s[g-1];
		end

		always_comb begin
			r2 = {rem_in, 1'b0};
			if (r2 >= {1'b0, d_in}) begin
				rem_nx = DW'(r2 - {1'b0, d_in});
				q_nx   = {q_in[QW-2:0], 1'b1};
			end else begin
				rem_nx = r2[DW-1:0];
				q_nx   = {q_in[QW-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (en) begin
				vld_s[g] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g] <= rem_nx;
				d_s[g]   <= d_in;
				q_s[g]   <= q_nx;
				pay_s[g] <= pay_in;
			end
		end
	end

	assign out_valid = vld_s[QW-1];
	assign quo       = q_s[QW-1];
	assign out_pay   = pay_s[QW-1];

endmodule

>>> src/tapered_segment_voxel_density_core.sv
// ----------------------------------------------------------------------------
// tapered_segment_voxel_density_core
// Density byte of one voxel against a tapered capsule around a vessel segment.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  cfg     | in        | psel/penable/pready    | paddr, pwdata, prdata
//  in      | in        | in_valid/in_ready      | voxel, endpoints, flows, prior
//  out     | out       | out_valid/out_ready    | voxel_density
//
//  one word enters per cycle while the output is not stalled; the pipeline
//  includes the 24-step flow root, the 16-step t divider, the 32-step distance
//  root and the 8-step density divider, each one bit per stage
//  arst_n clears the valid bits and the configuration registers to their reset values
//  the whole pipeline holds while the output word waits and out_ready is low
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tapered_segment_voxel_density_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [3:0]                           paddr,
	input  logic [31:0]                          pwdata,
	output logic [31:0]                          prdata,
	output logic                                 pready,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [tsvd_pkg::VOX_W-1:0]    voxel_x,
	input  logic signed [tsvd_pkg::VOX_W-1:0]    voxel_y,
	input  logic signed [tsvd_pkg::VOX_W-1:0]    voxel_z,
	input  logic signed [tsvd_pkg::POS_W-1:0]    start_x,
	input  logic signed [tsvd_pkg::POS_W-1:0]    start_y,
	input  logic signed [tsvd_pkg::POS_W-1:0]    start_z,
	input  logic signed [tsvd_pkg::POS_W-1:0]    end_x,
	input  logic signed [tsvd_pkg::POS_W-1:0]    end_y,
	input  logic signed [tsvd_pkg::POS_W-1:0]    end_z,
	input  logic [tsvd_pkg::FLOW_W-1:0]          start_flow,
	input  logic [tsvd_pkg::FLOW_W-1:0]          end_flow,
	input  logic [7:0]                           prior_density,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [7:0]                           voxel_density
);

	localparam int F      = tsvd_pkg::FRAC_BITS;
	localparam int CW     = tsvd_pkg::COORD_W;
	localparam int VW     = tsvd_pkg::VOX_W + F;
	localparam int AW     = tsvd_pkg::POS_W + tsvd_pkg::K_W + 1;
	localparam int DW39   = CW + 8;
	localparam int PW_    = 2 * tsvd_pkg::FLOW_W;
	localparam int RAD_W  = tsvd_pkg::RAD_W;
	localparam int SR_W   = tsvd_pkg::SROOT_W;
	localparam int TAB_W  = CW + tsvd_pkg::T_W + 1;
	localparam int RD_W   = RAD_W + 1 + tsvd_pkg::T_W + 1;
	localparam int DIFF_W = tsvd_pkg::DIST_W + 2;
	localparam int FZ_W   = tsvd_pkg::FZ_W;

	// configuration registers
	logic [tsvd_pkg::K_W-1:0] infl_q;
	logic [15:0]              scale_q;
	logic [15:0]              minr_q;
	logic [31:0]              jlim_q;
	logic [tsvd_pkg::K_W-1:0] k;
	logic                     wr;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign k      = (infl_q == '0) ? tsvd_pkg::K_W'(1) : infl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			infl_q  <= 5'd5;
			scale_q <= 16'd655;
			minr_q  <= 16'd7;
			jlim_q  <= 32'd655360;
		end else if (wr) begin
			case (tsvd_pkg::reg_idx_t'(paddr[3:2]))
				tsvd_pkg::REG_INFLATION:  infl_q  <= pwdata[tsvd_pkg::K_W-1:0];
				tsvd_pkg::REG_SCALE:      scale_q <= pwdata[15:0];
				tsvd_pkg::REG_MIN_RADIUS: minr_q  <= pwdata[15:0];
				tsvd_pkg::REG_JUMP_LIMIT: jlim_q  <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (tsvd_pkg::reg_idx_t'(paddr[3:2]))
			tsvd_pkg::REG_INFLATION:  prdata = 32'(infl_q);
			tsvd_pkg::REG_SCALE:      prdata = 32'(scale_q);
			tsvd_pkg::REG_MIN_RADIUS: prdata = 32'(minr_q);
			tsvd_pkg::REG_JUMP_LIMIT: prdata = jlim_q;
			default:                  prdata = '0;
		endcase
	end

	// global advance: every stage moves when the output register can take a word
	logic adv;
	logic out_valid_q;
	logic [7:0] out_q;

	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;

	// s1: scale positions, flow over pi
	logic signed [tsvd_pkg::VOX_W-1:0] vox [3];
	logic signed [tsvd_pkg::POS_W-1:0] sp [3];
	logic signed [tsvd_pkg::POS_W-1:0] ep [3];
	logic                valid_s1;
	logic signed [VW-1:0] v_s1 [3];
	logic signed [AW-1:0] a_s1 [3];
	logic signed [AW-1:0] b_s1 [3];
	logic [PW_-1:0]      fa_s1, fb_s1;
	logic [7:0]          prior_s1;

	assign vox[0] = voxel_x;
	assign vox[1] = voxel_y;
	assign vox[2] = voxel_z;
	assign sp[0]  = start_x;
	assign sp[1]  = start_y;
	assign sp[2]  = start_z;
	assign ep[0]  = end_x;
	assign ep[1]  = end_y;
	assign ep[2]  = end_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				v_s1[i] <= $signed({vox[i], {F{1'b0}}});
				a_s1[i] <= sp[i] * $signed({1'b0, k});
				b_s1[i] <= ep[i] * $signed({1'b0, k});
			end
			fa_s1    <= start_flow * tsvd_pkg::INV_PI_Q32;
			fb_s1    <= end_flow * tsvd_pkg::INV_PI_Q32;
			prior_s1 <= prior_density;
		end
	end

	// s2: saturated differences, radicands for the flow roots
	logic                  valid_s2;
	tsvd_pkg::geo_t        geo_s2;
	logic [1:0][tsvd_pkg::FLOW_RW-1:0] frad_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				geo_s2.pa[i] <= tsvd_pkg::sat_coord(DW39'(v_s1[i]) - DW39'(a_s1[i]));
				geo_s2.ab[i] <= tsvd_pkg::sat_coord(DW39'(b_s1[i]) - DW39'(a_s1[i]));
			end
			geo_s2.prior <= prior_s1;
			frad_s2[0]   <= tsvd_pkg::FLOW_RW'({fa_s1[PW_-2:32], {F{1'b0}}});
			frad_s2[1]   <= tsvd_pkg::FLOW_RW'({fb_s1[PW_-2:32], {F{1'b0}}});
		end
	end

	// flow roots, geometry rides along
	logic                        valid_r;
	logic [1:0][SR_W-1:0]        froot;
	logic [$bits(tsvd_pkg::geo_t)-1:0] geo_r_raw;
	tsvd_pkg::geo_t              geo_r;

	tsvd_isqrt #(
		.RW    (tsvd_pkg::FLOW_RW),
		.LANES (2),
		.PW    ($bits(tsvd_pkg::geo_t))
	) u_flow_root (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (valid_s2),
		.rad       (frad_s2),
		.in_pay    (geo_s2),
		.out_valid (valid_r),
		.root      (froot),
		.out_pay   (geo_r_raw)
	);

	assign geo_r = tsvd_pkg::geo_t'(geo_r_raw);

	// s3: scaled roots, products
	logic                 valid_s3;
	logic [SR_W-1:0]      rs_s3 [2];
	logic [2*CW-1:0]      abq_s3 [3];
	logic signed [2*CW-1:0] pd_s3 [3];
	tsvd_pkg::geo_t       geo_s3;
	logic [SR_W+15:0]     sc_c [2];

	always_comb begin
		for (int j = 0; j < 2; j++) begin
			sc_c[j] = froot[j] * scale_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= valid_r;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < 2; j++) begin
				rs_s3[j] <= sc_c[j][SR_W+15:tsvd_pkg::SCALE_FRAC];
			end
			for (int i = 0; i < 3; i++) begin
				abq_s3[i] <= $signed(geo_r.ab[i]) * $signed(geo_r.ab[i]);
				pd_s3[i]  <= $signed(geo_r.pa[i]) * $signed(geo_r.ab[i]);
			end
			geo_s3 <= geo_r;
		end
	end

	// s4: radius floor and inflation, length and dot sums
	logic                     valid_s4;
	tsvd_pkg::radius_t        r_s4 [2];
	logic [tsvd_pkg::LEN2_W-1:0] len2_s4;
	logic signed [63:0]       dot_s4;
	tsvd_pkg::geo_t           geo_s4;
	logic [SR_W-1:0]          rm_c [2];

	always_comb begin
		for (int j = 0; j < 2; j++) begin
			rm_c[j] = (rs_s3[j] < SR_W'(minr_q)) ? SR_W'(minr_q) : rs_s3[j];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < 2; j++) begin
				r_s4[j] <= rm_c[j] * k;
			end
			len2_s4 <= abq_s3[0] + abq_s3[1] + abq_s3[2];
			dot_s4  <= 64'(pd_s3[0]) + 64'(pd_s3[1]) + 64'(pd_s3[2]);
			geo_s4  <= geo_s3;
		end
	end

	// s5: radius jump, choice of t
	logic                     valid_s5;
	tsvd_pkg::seg_t           seg_s5;
	logic [tsvd_pkg::LEN2_W-1:0] dx_s5, dd_s5;
	tsvd_pkg::radius_t        jd_c;
	tsvd_pkg::tmode_t         mode_c;

	always_comb begin
		jd_c = (r_s4[0] > r_s4[1]) ? r_s4[0] - r_s4[1] : r_s4[1] - r_s4[0];
		if (len2_s4 == '0 || dot_s4 <= 64'sd0) begin
			mode_c = tsvd_pkg::T_ZERO;
		end else if (dot_s4 >= $signed(64'(len2_s4))) begin
			mode_c = tsvd_pkg::T_ONE;
		end else begin
			mode_c = tsvd_pkg::T_DIV;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (adv) begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			seg_s5.pa    <= geo_s4.pa;
			seg_s5.ab    <= geo_s4.ab;
			seg_s5.prior <= geo_s4.prior;
			seg_s5.rb    <= r_s4[1];
			seg_s5.ra    <= (32'(jd_c) > jlim_q) ? r_s4[1] : r_s4[0];
			seg_s5.mode  <= mode_c;
			dx_s5        <= dot_s4[tsvd_pkg::LEN2_W-1:0];
			dd_s5        <= len2_s4;
		end
	end

	// t divider
	logic                     valid_t;
	logic [F-1:0]             tq;
	logic [$bits(tsvd_pkg::seg_t)-1:0] seg_t_raw;
	tsvd_pkg::seg_t           seg_dv;

	tsvd_div #(
		.DW (tsvd_pkg::LEN2_W),
		.QW (F),
		.PW ($bits(tsvd_pkg::seg_t))
	) u_t_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (valid_s5),
		.x         (dx_s5),
		.d         (dd_s5),
		.in_pay    (seg_s5),
		.out_valid (valid_t),
		.quo       (tq),
		.out_pay   (seg_t_raw)
	);

	assign seg_dv = tsvd_pkg::seg_t'(seg_t_raw);

	// s6: t times axis and radius span
	logic                    valid_s6;
	logic signed [TAB_W-1:0] tab_s6 [3];
	logic signed [RD_W-1:0]  rd_s6;
	tsvd_pkg::seg_t          seg_s6;
	logic [tsvd_pkg::T_W-1:0] t_c;
	logic signed [RAD_W:0]   rdiff_c;

	always_comb begin
		case (seg_dv.mode)
			tsvd_pkg::T_ONE: t_c = tsvd_pkg::T_W'(1) << F;
			tsvd_pkg::T_DIV: t_c = {1'b0, tq};
			default:         t_c = '0;
		endcase
		rdiff_c = $signed({1'b0, seg_dv.rb}) - $signed({1'b0, seg_dv.ra});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else if (adv) begin
			valid_s6 <= valid_t;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				tab_s6[i] <= $signed(seg_dv.ab[i]) * $signed({1'b0, t_c});
			end
			rd_s6  <= rdiff_c * $signed({1'b0, t_c});
			seg_s6 <= seg_dv;
		end
	end

	// s7: error vector, interpolated radius
	logic                  valid_s7;
	logic signed [CW:0]    e_s7 [3];
	tsvd_pkg::radius_t     rad_s7;
	tsvd_pkg::radius_t     ra_s7, rb_s7;
	logic [7:0]            prior_s7;
	logic signed [TAB_W-1:0] tsh_c [3];
	logic signed [RD_W-1:0]  rsh_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			tsh_c[i] = tab_s6[i] >>> F;
		end
		rsh_c = rd_s6 >>> F;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s7 <= 1'b0;
		end else if (adv) begin
			valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				e_s7[i] <= {seg_s6.pa[i][CW-1], seg_s6.pa[i]} - tsh_c[i][CW:0];
			end
			rad_s7   <= seg_s6.ra + rsh_c[RAD_W-1:0];
			ra_s7    <= seg_s6.ra;
			rb_s7    <= seg_s6.rb;
			prior_s7 <= seg_s6.prior;
		end
	end

	// s8: squares
	logic                   valid_s8;
	logic [tsvd_pkg::DIST2_W-1:0] sq_s8 [3];
	tsvd_pkg::dist_pay_t    dp_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s8 <= 1'b0;
		end else if (adv) begin
			valid_s8 <= valid_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				sq_s8[i] <= e_s7[i] * e_s7[i];
			end
			dp_s8.rad   <= rad_s7;
			dp_s8.prior <= prior_s7;
		end
	end

	// s9: squared distance
	logic                         valid_s9;
	logic [0:0][tsvd_pkg::DIST2_W-1:0] d2_s9;
	tsvd_pkg::dist_pay_t          dp_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s9 <= 1'b0;
		end else if (adv) begin
			valid_s9 <= valid_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d2_s9[0] <= sq_s8[0] + sq_s8[1] + sq_s8[2];
			dp_s9    <= dp_s8;
		end
	end

	// distance root
	logic                          valid_d;
	logic [0:0][tsvd_pkg::DIST_W-1:0] droot;
	logic [$bits(tsvd_pkg::dist_pay_t)-1:0] dp_d_raw;
	tsvd_pkg::dist_pay_t           dp_d;

	tsvd_isqrt #(
		.RW    (tsvd_pkg::DIST2_W),
		.LANES (1),
		.PW    ($bits(tsvd_pkg::dist_pay_t))
	) u_dist_root (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (valid_s9),
		.rad       (d2_s9),
		.in_pay    (dp_s9),
		.out_valid (valid_d),
		.root      (droot),
		.out_pay   (dp_d_raw)
	);

	assign dp_d = tsvd_pkg::dist_pay_t'(dp_d_raw);

	// s10: overshoot past the radius, density class and divider operands
	logic                      valid_s10;
	tsvd_pkg::dens_pay_t       dn_s10;
	logic [tsvd_pkg::DX_W-1:0] dx_s10, dd_s10;
	logic signed [DIFF_W-1:0]  diff_c;
	logic [FZ_W-1:0]           fuzzy_c, n_c;
	logic [FZ_W+7:0]           num_c;
	tsvd_pkg::dclass_t         cls_c;

	always_comb begin
		diff_c  = $signed({2'b00, droot[0]}) - $signed(DIFF_W'(dp_d.rad));
		fuzzy_c = {k, {F{1'b0}}};
		n_c     = fuzzy_c - diff_c[FZ_W-1:0];
		num_c   = n_c * 8'd255;
		if (diff_c <= $signed(DIFF_W'(0))) begin
			cls_c = tsvd_pkg::D_FULL;
		end else if (diff_c >= $signed(DIFF_W'(fuzzy_c))) begin
			cls_c = tsvd_pkg::D_EMPTY;
		end else begin
			cls_c = tsvd_pkg::D_DIV;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s10 <= 1'b0;
		end else if (adv) begin
			valid_s10 <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dn_s10.cls   <= cls_c;
			dn_s10.prior <= dp_d.prior;
			// floor(255n / (k << F)) as floor((255n >> F) / k)
			dx_s10       <= num_c[FZ_W+7:F];
			dd_s10       <= {k, {tsvd_pkg::DQ_W{1'b0}}};
		end
	end

	// density divider
	logic                       valid_q;
	logic [tsvd_pkg::DQ_W-1:0]  dq;
	logic [$bits(tsvd_pkg::dens_pay_t)-1:0] dn_q_raw;
	tsvd_pkg::dens_pay_t        dn_q;
	logic [7:0]                 dens_c;

	tsvd_div #(
		.DW (tsvd_pkg::DX_W),
		.QW (tsvd_pkg::DQ_W),
		.PW ($bits(tsvd_pkg::dens_pay_t))
	) u_dens_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (valid_s10),
		.x         (dx_s10),
		.d         (dd_s10),
		.in_pay    (dn_s10),
		.out_valid (valid_q),
		.quo       (dq),
		.out_pay   (dn_q_raw)
	);

	assign dn_q = tsvd_pkg::dens_pay_t'(dn_q_raw);

	always_comb begin
		case (dn_q.cls)
			tsvd_pkg::D_FULL:  dens_c = 8'd255;
			tsvd_pkg::D_EMPTY: dens_c = 8'd0;
			default:           dens_c = 8'(dq);
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= (dens_c > dn_q.prior) ? dens_c : dn_q.prior;
		end
	end

	assign out_valid     = out_valid_q;
	assign voxel_density = out_q;

	`TSVD_ASSERT(a_zero_len_dot, clk, arst_n, (valid_s4 && len2_s4 == '0) |-> (dot_s4 == '0))
	`TSVD_ASSERT(a_rad_between, clk, arst_n, valid_s7 |-> ((rad_s7 >= ra_s7 || rad_s7 >= rb_s7) && (rad_s7 <= ra_s7 || rad_s7 <= rb_s7)))
	`TSVD_ASSERT(a_dens_div_range, clk, arst_n, (valid_s10 && dn_s10.cls == tsvd_pkg::D_DIV) |-> (dx_s10 < dd_s10))
	`TSVD_NEVER(a_stall_moves, clk, arst_n, !$past(adv) && (valid_s2 != $past(valid_s2)))

endmodule

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the tapered segment voxel density core. Directed rows
// and random voxel/segment words are streamed through valid/ready with random
// idling on both sides; a bit-accurate predictor supplies expected densities.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY = 91;

	typedef struct {
		logic signed [19:0] vx, vy, vz;
		logic signed [31:0] sx, sy, sz, ex, ey, ez;
		logic [31:0] fs, fe;
		logic [7:0] prior;
		int want; // -1: use predictor
	} voxel_word_t;

	logic clk, arst_n;
	logic psel, penable, pwrite;
	logic [3:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;
	logic in_valid, in_ready, out_valid, out_ready;
	logic signed [19:0] voxel_x, voxel_y, voxel_z;
	logic signed [31:0] start_x, start_y, start_z, end_x, end_y, end_z;
	logic [31:0] start_flow, end_flow;
	logic [7:0] prior_density, voxel_density;

	tapered_segment_voxel_density_core DUT (.*);

	// shadow copy of the registers
	logic [4:0] k_reg;
	logic [15:0] scale_reg, rmin_reg;
	logic [31:0] jump_reg;

	logic [7:0] density_queue[$];
	int errors, words_sent, words_checked;
	bit hold_off, hold_done;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#200ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic longint isqrt(input longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic longint fshift(input longint v);
		return v >>> tsvd_pkg::FRAC_BITS;
	endfunction

	function automatic longint clamp_diff(input longint v);
		if (v > 64'sd1073741823) return 64'sd1073741823;
		if (v < -64'sd1073741823) return -64'sd1073741823;
		return v;
	endfunction

	function automatic longint flow_radius(input logic [31:0] flow, input longint k);
		longint unsigned q, s, r;
		q = (64'(flow) * 64'd1367130551) >> 32;
		s = isqrt(q << tsvd_pkg::FRAC_BITS);
		r = (s * 64'(scale_reg)) >> 16;
		if (r < 64'(rmin_reg)) r = rmin_reg;
		r *= k;
		if (r > 64'hFFFF_FFFF) r = 64'hFFFF_FFFF;
		return r;
	endfunction

	function automatic logic [7:0] predict_density(input voxel_word_t w);
		longint k, pa[3], ab[3], e[3], t, ra, rb, jump, dist_len, rad, diff, fuzzy, dot;
		longint unsigned len2, dist2, rem, q, dens;
		longint vv[3], aa[3], bb[3];
		k = (k_reg == 0) ? 1 : k_reg;
		vv = '{w.vx, w.vy, w.vz};
		aa = '{w.sx, w.sy, w.sz};
		bb = '{w.ex, w.ey, w.ez};
		len2 = 0;
		dist2 = 0;
		t = 0;
		for (int i = 0; i < 3; i++) begin
			pa[i] = clamp_diff(vv[i] * 65536 - aa[i] * k);
			ab[i] = clamp_diff(bb[i] * k - aa[i] * k);
			len2 += ab[i] * ab[i];
		end
		ra = flow_radius(w.fs, k);
		rb = flow_radius(w.fe, k);
		jump = ra - rb;
		if (jump < 0) jump = -jump;
		if (jump > longint'(jump_reg)) ra = rb;
		if (len2 != 0) begin
			dot = pa[0] * ab[0] + pa[1] * ab[1] + pa[2] * ab[2];
			if (dot <= 0) begin
				t = 0;
			end else if (longint'(dot) >= len2) begin
				t = 65536;
			end else begin
				rem = dot;
				q = 0;
				for (int i = 0; i < tsvd_pkg::FRAC_BITS; i++) begin
					rem <<= 1;
					q <<= 1;
					if (rem >= len2) begin
						rem -= len2;
						q |= 1;
					end
				end
				t = q;
			end
		end
		for (int i = 0; i < 3; i++) begin
			e[i] = pa[i] - fshift(t * ab[i]);
			dist2 += e[i] * e[i];
		end
		dist_len = isqrt(dist2);
		rad = ra + fshift((rb - ra) * t);
		diff = dist_len - rad;
		fuzzy = k * 65536;
		if (diff <= 0) dens = 255;
		else if (diff >= fuzzy) dens = 0;
		else dens = (255 * (fuzzy - diff)) / fuzzy;
		return (dens > w.prior) ? dens[7:0] : w.prior;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		errors++;
		$display("mismatch on %s: got %0d, expected %0d", what, got, want);
	endtask

	task automatic write_reg(input tsvd_pkg::reg_idx_t idx, input logic [31:0] value);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		// psel stays high: setup cycle of the read back
		penable <= 0;
		pwrite <= 0;
		case (idx)
			tsvd_pkg::REG_INFLATION: k_reg = value[4:0];
			tsvd_pkg::REG_SCALE: scale_reg = value[15:0];
			tsvd_pkg::REG_MIN_RADIUS: rmin_reg = value[15:0];
			tsvd_pkg::REG_JUMP_LIMIT: jump_reg = value;
			default: ;
		endcase
		@(negedge clk);
		penable <= 1;
		@(posedge clk);
		case (idx)
			tsvd_pkg::REG_INFLATION: if (prdata[4:0] !== k_reg)
				report_mismatch("readback", prdata, k_reg);
			tsvd_pkg::REG_SCALE: if (prdata[15:0] !== scale_reg)
				report_mismatch("readback", prdata, scale_reg);
			tsvd_pkg::REG_MIN_RADIUS: if (prdata[15:0] !== rmin_reg)
				report_mismatch("readback", prdata, rmin_reg);
			tsvd_pkg::REG_JUMP_LIMIT: if (prdata !== jump_reg)
				report_mismatch("readback", prdata, jump_reg);
			default: ;
		endcase
		@(negedge clk);
		psel <= 0;
		penable <= 0;
		@(negedge clk);
	endtask

	// idle so that a later register write sees an empty pipeline
	task automatic drain();
		in_valid <= 0;
		while (density_queue.size() != 0) @(negedge clk);
		repeat (LATENCY + 10) @(negedge clk);
	endtask

	bit send_gaps = 1;

	task automatic send_word(input voxel_word_t w);
		while (send_gaps && $urandom_range(99) < 24) begin
			in_valid <= 0;
			@(negedge clk);
		end
		density_queue.insert(density_queue.size(),
			w.want >= 0 ? 8'(w.want) : predict_density(w));
		in_valid <= 1;
		voxel_x <= w.vx; voxel_y <= w.vy; voxel_z <= w.vz;
		start_x <= w.sx; start_y <= w.sy; start_z <= w.sz;
		end_x <= w.ex; end_y <= w.ey; end_z <= w.ez;
		start_flow <= w.fs; end_flow <= w.fe;
		prior_density <= w.prior;
		do @(posedge clk); while (!in_ready);
		words_sent++;
		@(negedge clk);
	endtask

	function automatic logic [31:0] rand_pos(input int shape);
		case (shape)
			0: return $urandom;
			default: return 32'($signed($urandom_range(8 * 65536)) - 4 * 65536);
		endcase
	endfunction

	// well-formed word: voxel near a short segment so densities land in the fuzzy band
	function automatic voxel_word_t random_word();
		voxel_word_t w;
		int shape, k;
		k = (k_reg == 0) ? 1 : k_reg;
		shape = ($urandom_range(9) == 0) ? 0 : 1;
		w.sx = rand_pos(shape); w.sy = rand_pos(shape); w.sz = rand_pos(shape);
		if ($urandom_range(9) == 0) begin
			w.ex = w.sx; w.ey = w.sy; w.ez = w.sz;
		end else begin
			w.ex = rand_pos(shape); w.ey = rand_pos(shape); w.ez = rand_pos(shape);
		end
		if (shape == 0) begin
			w.vx = $urandom; w.vy = $urandom; w.vz = $urandom;
		end else begin
			w.vx = 20'((longint'(w.sx) * k >>> 16) + $signed($urandom_range(40)) - 20);
			w.vy = 20'((longint'(w.sy) * k >>> 16) + $signed($urandom_range(40)) - 20);
			w.vz = 20'((longint'(w.sz) * k >>> 16) + $signed($urandom_range(40)) - 20);
		end
		w.fs = ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h0100_0000);
		w.fe = ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h0100_0000);
		w.prior = ($urandom_range(2) == 0) ? 8'($urandom) : 8'd0;
		w.want = -1;
		return w;
	endfunction

	always @(negedge clk) begin
		if (!arst_n || hold_off) out_ready <= 0;
		else if (send_gaps) out_ready <= ($urandom_range(99) >= 24);
		else out_ready <= 1;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (density_queue.size() == 0) begin
				report_mismatch("unexpected density", voxel_density, -1);
			end else begin
				if (voxel_density !== density_queue[0])
					report_mismatch("voxel_density", voxel_density, density_queue[0]);
				void'(density_queue.pop_front());
				words_checked++;
			end
		end
	end

	// one long receiver stall while the sender keeps going
	initial begin
		hold_off = 0;
		wait (words_sent >= 400);
		@(negedge clk);
		hold_off = 1;
		repeat (300) @(negedge clk);
		hold_off = 0;
		hold_done = 1;
	end

	voxel_word_t directed_rows[$];

	initial begin
		voxel_word_t w;
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		in_valid = 0; out_ready = 0;
		voxel_x = 0; voxel_y = 0; voxel_z = 0;
		start_x = 0; start_y = 0; start_z = 0; end_x = 0; end_y = 0; end_z = 0;
		start_flow = 0; end_flow = 0; prior_density = 0;
		errors = 0; words_sent = 0; words_checked = 0;
		k_reg = 5; scale_reg = 655; rmin_reg = 7; jump_reg = 655360;
		arst_n = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: voxel on start point is inside, far voxel is empty, prior dominates
		directed_rows = '{
			'{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 8'd0, 255},
			'{0, 0, 0, 0, 0, 0, 65536, 0, 0, 0, 0, 8'd0, 255},
			'{20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF, 0, 0, 0, 0, 0, 0, 0, 0, 8'd0, 0},
			'{20'sh80000, 20'sh80000, 20'sh80000, 0, 0, 0, 0, 0, 0, 0, 0, 8'd77, 77},
			'{100, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 8'hFF, 255},
			'{0, 0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
				32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 8'd0, -1},
			'{0, 0, 0, 32'h80000000, 0, 0, 32'h7FFFFFFF, 0, 0,
				32'hFFFFFFFF, 32'hFFFFFFFF, 8'd0, -1},
			'{3, 4, 0, 0, 0, 0, 65536, 65536, 0, 32'hFFFFFFFF, 0, 8'd0, -1},
			'{6, 0, 0, 0, 0, 0, 65536, 0, 0, 32'h0010_0000, 32'h0001_0000, 8'd3, -1},
			'{-3, 2, 1, 0, 0, 0, 0, 0, 0, 32'h0004_0000, 32'h0004_0000, 8'd0, -1},
			'{2, 2, 0, -65536, 0, 0, 65536, 0, 0, 32'h0200_0000, 32'h0000_1000, 8'd0, -1},
			'{-8, 1, 1, 0, 0, 0, 65536, 0, 0, 0, 32'h0100_0000, 8'd10, -1}
		};
		foreach (directed_rows[i]) send_word(directed_rows[i]);
		drain();

		// register sweep including extremes, random words in each phase
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin write_reg(tsvd_pkg::REG_INFLATION, 1);
					write_reg(tsvd_pkg::REG_SCALE, 0);
					write_reg(tsvd_pkg::REG_MIN_RADIUS, 0);
					write_reg(tsvd_pkg::REG_JUMP_LIMIT, 0); end
				1: begin write_reg(tsvd_pkg::REG_INFLATION, 16);
					write_reg(tsvd_pkg::REG_SCALE, 16'hFFFF);
					write_reg(tsvd_pkg::REG_MIN_RADIUS, 16'hFFFF);
					write_reg(tsvd_pkg::REG_JUMP_LIMIT, 32'hFFFFFFFF); end
				2: begin write_reg(tsvd_pkg::REG_INFLATION, 0);
					write_reg(tsvd_pkg::REG_SCALE, 6553);
					write_reg(tsvd_pkg::REG_MIN_RADIUS, 1000);
					write_reg(tsvd_pkg::REG_JUMP_LIMIT, 65536); end
				3: begin write_reg(tsvd_pkg::REG_INFLATION, 31);
					write_reg(tsvd_pkg::REG_SCALE, 3000);
					write_reg(tsvd_pkg::REG_MIN_RADIUS, 20000);
					write_reg(tsvd_pkg::REG_JUMP_LIMIT, 655360); end
				4: begin write_reg(tsvd_pkg::REG_INFLATION, $urandom_range(1, 16));
					write_reg(tsvd_pkg::REG_SCALE, $urandom);
					write_reg(tsvd_pkg::REG_MIN_RADIUS, $urandom);
					write_reg(tsvd_pkg::REG_JUMP_LIMIT, $urandom); end
				default: begin write_reg(tsvd_pkg::REG_INFLATION, 5);
					write_reg(tsvd_pkg::REG_SCALE, 655);
					write_reg(tsvd_pkg::REG_MIN_RADIUS, 7);
					write_reg(tsvd_pkg::REG_JUMP_LIMIT, 655360); end
			endcase
			// back-to-back stretch without idling in one phase
			send_gaps = (phase != 2);
			for (int n = 0; n < 250; n++) begin
				w = random_word();
				send_word(w);
			end
			send_gaps = 1;
			drain();
		end

		wait (hold_done);
		$display("%0d words checked over six register settings plus directed corners",
			words_checked);
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule

>>> sim.f
+incdir+src
src/tsvd_pkg.sv
src/tsvd_isqrt.sv
src/tsvd_div.sv
src/tapered_segment_voxel_density_core.sv
test/tb.sv
